FILE: rtl/core/slr_pkg.sv
package slr_pkg;

	// field and datapath widths
	localparam int COORD_W             = 32;
	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int RATIO_FRAC          = 24;
	localparam int MAG_W               = 33;
	localparam int RATIO_W             = 31;
	localparam int SQ_W                = 63;
	localparam int ROOT_IN_W           = 64;
	localparam int SCALE_W             = 63;
	localparam int DEN_W               = 51;
	localparam int SNUM_W              = 83;

	// register reset values
	localparam logic [31:0] PITCH_RST = 32'd21474836;
	localparam logic [31:0] FOCAL_RST = 32'd16777216;

	// fixed-point constants: 1.0 in Q.48, 2.0^2 in Q.48, scale numerators
	localparam logic [ROOT_IN_W-1:0] ROOT_BIAS = 64'd1 << (2 * RATIO_FRAC);
	localparam logic [ROOT_IN_W-1:0] INV_ONE   = 64'd1 << (2 * RATIO_FRAC + 2);
	// (r/f)^2 at or above this leaves the inverse scale out of range
	localparam logic [SQ_W-1:0]      INV_LIMIT = 63'((64'd1 << 50) - (64'd1 << 19));
	localparam logic [SNUM_W-1:0]    FWD_NUM   = 83'd1 << (RATIO_FRAC + 33);
	localparam logic [SNUM_W-1:0]    INV_NUM   = 83'd1 << (2 * RATIO_FRAC + 34);
	localparam logic [DEN_W-1:0]     FWD_BIAS  = 51'd1 << RATIO_FRAC;
	localparam logic [MAG_W:0]       MAG_CAP   = 34'h2_0000_0000;

	localparam logic OP_FORWARD = 1'b0;
	localparam logic OP_INVERSE = 1'b1;

	localparam logic [1:0] ST_NORMAL = 2'd0;
	localparam logic [1:0] ST_CENTER = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;

	typedef enum logic [1:0] {
		REG_PRINCIPAL_X,
		REG_PRINCIPAL_Y,
		REG_PIXEL_PITCH,
		REG_FOCAL_LENGTH
	} reg_idx_t;

	typedef struct packed {
		reg_idx_t    index;
		logic [31:0] wdata;
	} cfg_req_t;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] in_col;
		logic signed [31:0] in_row;
	} pix_req_t;

	typedef struct packed {
		logic signed [31:0] out_col;
		logic signed [31:0] out_row;
		logic [1:0]         status;
	} pix_rsp_t;

	// per-item side data carried down the pipeline
	typedef struct packed {
		logic             opcode;
		logic [MAG_W-1:0] mag_x;
		logic [MAG_W-1:0] mag_y;
		logic             neg_x;
		logic             neg_y;
		logic             center;
		logic             sat;
	} axis_tag_t;

	typedef struct packed {
		axis_tag_t        axis;
		logic [DEN_W-1:0] den;
	} root_tag_t;

endpackage

FILE: rtl/core/slr_stream_if.sv
interface slr_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/stereographic_lens_remap.sv
// Stereographic lens remap: maps a Q16.16 pixel coordinate through a
// stereographic lens model about the principal point, forward or inverse.
// pix_in carries requests (opcode, in_col, in_row); pix_out carries one
// result (out_col, out_row, status) per request, in order. cfg writes the
// principal point, pixel pitch and focal length; it is always ready and
// must be written only while no request is in flight.
// One request is taken every cycle unless pix_out stalls. From acceptance
// to pix_out.valid lie 3 setup stages, 31 ratio divide stages, 2 square/sum
// stages, 32 square-root stages, 1 select stage, 63 scale divide stages and
// 3 output stages. The pipeline advances as a whole: when a result waits on
// pix_out and pix_out.ready is low, every stage holds and pix_in.ready
// drops until that result is taken; nothing is lost or repeated.
// Reset (arst_n low) empties the pipeline and returns the registers to
// principal 0, pitch 21474836 (2^-32 mm units) and focal length 16 mm.
module stereographic_lens_remap #(
	parameter int COORD_FRAC_BITS = slr_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	slr_stream_if.sink   pix_in,
	slr_stream_if.source pix_out,
	slr_stream_if.sink   cfg
);
	import slr_pkg::*;

	// configuration registers
	logic signed [31:0] principal_x_q, principal_y_q;
	logic [31:0]        pixel_pitch_q, focal_length_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			principal_x_q  <= '0;
			principal_y_q  <= '0;
			pixel_pitch_q  <= PITCH_RST;
			focal_length_q <= FOCAL_RST;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_PRINCIPAL_X:  principal_x_q  <= cfg.data.wdata;
				REG_PRINCIPAL_Y:  principal_y_q  <= cfg.data.wdata;
				REG_PIXEL_PITCH:  pixel_pitch_q  <= cfg.data.wdata;
				REG_FOCAL_LENGTH: focal_length_q <= cfg.data.wdata;
				default: ;
			endcase
		end
	end

	// whole-pipeline advance
	logic en;
	logic out_valid;
	assign en           = !out_valid || pix_out.ready;
	assign pix_in.ready = en;

	logic                 v_front;
	logic [RATIO_W-1:0]   ratio_x, ratio_y;
	axis_tag_t            tag_front;

	slr_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (pix_in.valid),
		.in_data      (pix_in.data),
		.principal_x  (principal_x_q),
		.principal_y  (principal_y_q),
		.pixel_pitch  (pixel_pitch_q),
		.focal_length (focal_length_q),
		.out_valid    (v_front),
		.ratio_x      (ratio_x),
		.ratio_y      (ratio_y),
		.out_tag      (tag_front)
	);

	logic               v_norm;
	logic [SCALE_W-1:0] scale;
	axis_tag_t          tag_norm;

	slr_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_front),
		.ratio_x   (ratio_x),
		.ratio_y   (ratio_y),
		.in_tag    (tag_front),
		.out_valid (v_norm),
		.scale     (scale),
		.out_tag   (tag_norm)
	);

	pix_rsp_t rsp;

	slr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (v_norm),
		.scale       (scale),
		.in_tag      (tag_norm),
		.principal_x (principal_x_q),
		.principal_y (principal_y_q),
		.out_valid   (out_valid),
		.out_data    (rsp)
	);

	assign pix_out.valid = out_valid;
	assign pix_out.data  = rsp;

	// a result never carries the unused status code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid |-> pix_out.data.status != 2'd3)
		else $error("status code 3 on pix_out");

	// a centre result returns the principal point
	a_center_point: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && pix_out.data.status == ST_CENTER) |->
		(pix_out.data.out_col == principal_x_q && pix_out.data.out_row == principal_y_q))
		else $error("centre result differs from principal point");

	// the first cycle after reset has an empty pipeline
	a_reset_empty: assert property (@(posedge clk)
		!$past(arst_n) |-> !pix_out.valid)
		else $error("result valid right after reset");
endmodule

FILE: rtl/core/slr_div_pipe.sv
// Restoring divider, one quotient bit per stage. Requires num < den * 2^QB.
module slr_div_pipe #(
	parameter int NW = 64,
	parameter int DW = 32,
	parameter int QB = 31,
	parameter type tag_t = logic
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  tag_t          tag_in,
	output logic          out_valid,
	output logic [QB-1:0] quo,
	output tag_t          tag_out
);
	localparam int RW = (NW > DW + QB) ? NW : DW + QB;

	logic          v_s   [QB];
	logic [NW-1:0] rem_s [QB];
	logic [DW-1:0] den_s [QB];
	logic [QB-1:0] quo_s [QB];
	tag_t          tag_s [QB];

	for (genvar j = 0; j < QB; j++) begin : g_stage
		localparam int BIT = QB - 1 - j;
		logic          v_i;
		logic [NW-1:0] rem_i;
		logic [DW-1:0] den_i;
		logic [QB-1:0] quo_i;
		tag_t          t_i;
		logic [RW-1:0] trial;
		logic          take;

		if (j == 0) begin : g_head
			assign v_i   = in_valid;
			assign rem_i = num;
			assign den_i = den;
			assign quo_i = '0;
			assign t_i   = tag_in;
		end else begin : g_body
			assign v_i   = v_s[j-1];
			assign rem_i = rem_s[j-1];
			assign den_i = den_s[j-1];
			assign quo_i = quo_s[j-1];
			assign t_i   = tag_s[j-1];
		end

		// trial subtract of the shifted divisor
		assign trial = RW'(den_i) << BIT;
		assign take  = RW'(rem_i) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= take ? rem_i - trial[NW-1:0] : rem_i;
				quo_s[j] <= {quo_i[QB-2:0], take};
				den_s[j] <= den_i;
				tag_s[j] <= t_i;
			end
		end
	end

	assign out_valid = v_s[QB-1];
	assign quo       = quo_s[QB-1];
	assign tag_out   = tag_s[QB-1];
endmodule

FILE: rtl/core/slr_sqrt_pipe.sv
// Digit-by-digit integer square root, one root bit per stage.
module slr_sqrt_pipe #(
	parameter int XW = 64,
	parameter type tag_t = logic
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [XW-1:0]   x,
	input  tag_t            tag_in,
	output logic            out_valid,
	output logic [XW/2-1:0] root,
	output tag_t            tag_out
);
	localparam int HW = XW / 2;

	logic          v_s    [HW];
	logic [XW-1:0] x_s    [HW];
	logic [HW:0]   rem_s  [HW];
	logic [HW-1:0] root_s [HW];
	tag_t          tag_s  [HW];

	for (genvar j = 0; j < HW; j++) begin : g_stage
		logic          v_i;
		logic [XW-1:0] x_i;
		logic [HW:0]   rem_i;
		logic [HW-1:0] root_i;
		tag_t          t_i;
		logic [HW+2:0] pre;
		logic [HW+2:0] trial;
		logic          take;

		if (j == 0) begin : g_head
			assign v_i    = in_valid;
			assign x_i    = x;
			assign rem_i  = '0;
			assign root_i = '0;
			assign t_i    = tag_in;
		end else begin : g_body
			assign v_i    = v_s[j-1];
			assign x_i    = x_s[j-1];
			assign rem_i  = rem_s[j-1];
			assign root_i = root_s[j-1];
			assign t_i    = tag_s[j-1];
		end

		// bring down the next bit pair, try 4*root + 1
		assign pre   = {rem_i, x_i[XW-1:XW-2]};
		assign trial = (HW+3)'({root_i, 2'b01});
		assign take  = pre >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= take ? (HW+1)'(pre - trial) : (HW+1)'(pre);
				root_s[j] <= {root_i[HW-2:0], take};
				x_s[j]    <= {x_i[XW-3:0], 2'b00};
				tag_s[j]  <= t_i;
			end
		end
	end

	assign out_valid = v_s[HW-1];
	assign root      = root_s[HW-1];
	assign tag_out   = tag_s[HW-1];
endmodule

FILE: rtl/core/slr_front.sv
// Offsets, pitch scaling and the r/f ratio per axis.
module slr_front #(
	parameter int COORD_FRAC_BITS = slr_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  slr_pkg::pix_req_t              in_data,
	input  logic signed [31:0]             principal_x,
	input  logic signed [31:0]             principal_y,
	input  logic [31:0]                    pixel_pitch,
	input  logic [31:0]                    focal_length,
	output logic                           out_valid,
	output logic [slr_pkg::RATIO_W-1:0]    ratio_x,
	output logic [slr_pkg::RATIO_W-1:0]    ratio_y,
	output slr_pkg::axis_tag_t             out_tag
);
	import slr_pkg::*;

	localparam int EX  = RATIO_FRAC - COORD_FRAC_BITS - 12;
	localparam int EXL = (EX > 0) ? EX : 0;
	localparam int SHR = (EX < 0) ? -EX : 0;
	localparam int NW  = 64 + EXL;
	localparam int DW  = 32 + SHR;
	localparam int CW  = (NW > DW + RATIO_W) ? NW : DW + RATIO_W;

	// s1: offsets from the principal point, sign and magnitude
	logic signed [32:0] dx, dy;
	logic               v_s1, op_s1, negx_s1, negy_s1;
	logic [MAG_W-1:0]   mx_s1, my_s1;

	assign dx = 33'(in_data.in_col) - 33'(principal_x);
	assign dy = 33'(in_data.in_row) - 33'(principal_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= in_data.opcode;
			negx_s1 <= dx[32];
			negy_s1 <= dy[32];
			mx_s1   <= dx[32] ? MAG_W'(-dx) : MAG_W'(dx);
			my_s1   <= dy[32] ? MAG_W'(-dy) : MAG_W'(dy);
		end
	end

	// s2: millimetre offsets
	logic [64:0] prod_x, prod_y;
	logic        v_s2;
	logic [63:0] nx_s2, ny_s2;
	axis_tag_t   tag_s2;

	assign prod_x = 65'(mx_s1) * 65'(pixel_pitch);
	assign prod_y = 65'(my_s1) * 65'(pixel_pitch);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s2         <= prod_x[63:0];
			ny_s2         <= prod_y[63:0];
			tag_s2.opcode <= op_s1;
			tag_s2.mag_x  <= mx_s1;
			tag_s2.mag_y  <= my_s1;
			tag_s2.neg_x  <= negx_s1;
			tag_s2.neg_y  <= negy_s1;
			tag_s2.center <= 1'b0;
			tag_s2.sat    <= 1'b0;
		end
	end

	// s3: ratio dividend/divisor, centre, overflow and zero-focal checks
	logic [NW-1:0] num_x, num_y;
	logic [DW-1:0] den;
	logic [CW-1:0] lim;
	logic          over_x, over_y;
	logic          v_s3;
	logic [NW-1:0] numx_s3, numy_s3;
	logic [DW-1:0] den_s3;
	axis_tag_t     tag_s3;

	assign num_x  = NW'(nx_s2) << EXL;
	assign num_y  = NW'(ny_s2) << EXL;
	assign den    = DW'(focal_length) << SHR;
	assign lim    = CW'(den) << RATIO_W;
	assign over_x = CW'(num_x) >= lim;
	assign over_y = CW'(num_y) >= lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s3       <= num_x;
			numy_s3       <= num_y;
			den_s3        <= den;
			tag_s3.opcode <= tag_s2.opcode;
			tag_s3.mag_x  <= tag_s2.mag_x;
			tag_s3.mag_y  <= tag_s2.mag_y;
			tag_s3.neg_x  <= tag_s2.neg_x;
			tag_s3.neg_y  <= tag_s2.neg_y;
			tag_s3.center <= (nx_s2 == '0) && (ny_s2 == '0);
			tag_s3.sat    <= (focal_length == '0) || over_x || over_y;
		end
	end

	slr_div_pipe #(.NW(NW), .DW(DW), .QB(RATIO_W), .tag_t(axis_tag_t)) u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.num       (numx_s3),
		.den       (den_s3),
		.tag_in    (tag_s3),
		.out_valid (out_valid),
		.quo       (ratio_x),
		.tag_out   (out_tag)
	);

	slr_div_pipe #(.NW(NW), .DW(DW), .QB(RATIO_W), .tag_t(logic)) u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.num       (numy_s3),
		.den       (den_s3),
		.tag_in    (1'b0),
		.out_valid (),
		.quo       (ratio_y),
		.tag_out   ()
	);
endmodule

FILE: rtl/core/slr_norm.sv
// Squared radius, forward root, and the lens scale division.
module slr_norm (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [slr_pkg::RATIO_W-1:0]   ratio_x,
	input  logic [slr_pkg::RATIO_W-1:0]   ratio_y,
	input  slr_pkg::axis_tag_t            in_tag,
	output logic                          out_valid,
	output logic [slr_pkg::SCALE_W-1:0]   scale,
	output slr_pkg::axis_tag_t            out_tag
);
	import slr_pkg::*;

	// s1: squares
	logic        v_s1;
	logic [61:0] sqx_s1, sqy_s1;
	axis_tag_t   tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1 <= 62'(ratio_x) * 62'(ratio_x);
			sqy_s1 <= 62'(ratio_y) * 62'(ratio_y);
			tag_s1 <= in_tag;
		end
	end

	// s2: sum, root operand, inverse denominator and range check
	logic [SQ_W-1:0]      s_sum;
	logic                 v_s2;
	logic [ROOT_IN_W-1:0] x_s2;
	root_tag_t            rtag_s2;

	assign s_sum = SQ_W'(sqx_s1) + SQ_W'(sqy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2                <= ROOT_BIAS + ROOT_IN_W'(s_sum);
			rtag_s2.den         <= DEN_W'(INV_ONE - ROOT_IN_W'(s_sum));
			rtag_s2.axis.opcode <= tag_s1.opcode;
			rtag_s2.axis.mag_x  <= tag_s1.mag_x;
			rtag_s2.axis.mag_y  <= tag_s1.mag_y;
			rtag_s2.axis.neg_x  <= tag_s1.neg_x;
			rtag_s2.axis.neg_y  <= tag_s1.neg_y;
			rtag_s2.axis.center <= tag_s1.center;
			rtag_s2.axis.sat    <= tag_s1.sat ||
				((tag_s1.opcode == OP_INVERSE) && (s_sum >= INV_LIMIT));
		end
	end

	logic                 v_rt;
	logic [ROOT_IN_W/2-1:0] root;
	root_tag_t            rtag_rt;

	slr_sqrt_pipe #(.XW(ROOT_IN_W), .tag_t(root_tag_t)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.x         (x_s2),
		.tag_in    (rtag_s2),
		.out_valid (v_rt),
		.root      (root),
		.tag_out   (rtag_rt)
	);

	// s3: pick the scale dividend and divisor by direction
	logic              v_s3;
	logic [SNUM_W-1:0] num_s3;
	logic [DEN_W-1:0]  den_s3;
	axis_tag_t         tag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_rt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s3 <= rtag_rt.axis;
			if (rtag_rt.axis.opcode == OP_FORWARD) begin
				num_s3 <= FWD_NUM;
				den_s3 <= DEN_W'(root) + FWD_BIAS;
			end else begin
				num_s3 <= INV_NUM;
				den_s3 <= rtag_rt.den;
			end
		end
	end

	slr_div_pipe #(.NW(SNUM_W), .DW(DEN_W), .QB(SCALE_W), .tag_t(axis_tag_t)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.num       (num_s3),
		.den       (den_s3),
		.tag_in    (tag_s3),
		.out_valid (out_valid),
		.quo       (scale),
		.tag_out   (out_tag)
	);
endmodule

FILE: rtl/core/slr_back.sv
// Apply the scale per axis, saturate and form the result.
module slr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [slr_pkg::SCALE_W-1:0]   scale,
	input  slr_pkg::axis_tag_t            in_tag,
	input  logic signed [31:0]            principal_x,
	input  logic signed [31:0]            principal_y,
	output logic                          out_valid,
	output slr_pkg::pix_rsp_t             out_data
);
	import slr_pkg::*;

	function automatic logic signed [31:0] dir_sat(input logic neg, input logic zero,
		input logic signed [31:0] p);
		if (neg) begin
			return 32'sh8000_0000;
		end else if (zero) begin
			return p;
		end
		return 32'sh7FFF_FFFF;
	endfunction

	// s1: partial products against the high and low scale words
	logic [63:0] hx_p, hy_p;
	logic [64:0] lx_p, ly_p;
	logic        v_s1;
	logic [63:0] hx_s1, hy_s1;
	logic [31:0] lx_s1, ly_s1;
	axis_tag_t   tag_s1;

	assign hx_p = 64'(in_tag.mag_x) * 64'(scale[62:32]);
	assign hy_p = 64'(in_tag.mag_y) * 64'(scale[62:32]);
	assign lx_p = 65'(in_tag.mag_x) * 65'(scale[31:0]);
	assign ly_p = 65'(in_tag.mag_y) * 65'(scale[31:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hx_s1  <= hx_p;
			hy_s1  <= hy_p;
			lx_s1  <= lx_p[63:32];
			ly_s1  <= ly_p[63:32];
			tag_s1 <= in_tag;
		end
	end

	// s2: magnitude, clamped
	logic [63:0]  mx, my;
	logic         v_s2;
	logic [MAG_W:0] mx_s2, my_s2;
	axis_tag_t    tag_s2;

	assign mx = hx_s1 + 64'(lx_s1);
	assign my = hy_s1 + 64'(ly_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2  <= (mx > 64'(MAG_CAP)) ? MAG_CAP : mx[MAG_W:0];
			my_s2  <= (my > 64'(MAG_CAP)) ? MAG_CAP : my[MAG_W:0];
			tag_s2 <= tag_s1;
		end
	end

	// s3: add to the principal point, clamp, pick the special cases
	logic signed [34:0] vx, vy;
	logic signed [31:0] cx, cy;
	logic               ovx, ovy;
	logic               v_s3;
	pix_rsp_t           rsp_s3;

	assign vx = tag_s2.neg_x ? 35'(principal_x) - 35'(mx_s2) : 35'(principal_x) + 35'(mx_s2);
	assign vy = tag_s2.neg_y ? 35'(principal_y) - 35'(my_s2) : 35'(principal_y) + 35'(my_s2);

	always_comb begin
		ovx = 1'b1;
		ovy = 1'b1;
		if (vx > 35'sh0_7FFF_FFFF) begin
			cx = 32'sh7FFF_FFFF;
		end else if (vx < -35'sh0_8000_0000) begin
			cx = 32'sh8000_0000;
		end else begin
			cx  = vx[31:0];
			ovx = 1'b0;
		end
		if (vy > 35'sh0_7FFF_FFFF) begin
			cy = 32'sh7FFF_FFFF;
		end else if (vy < -35'sh0_8000_0000) begin
			cy = 32'sh8000_0000;
		end else begin
			cy  = vy[31:0];
			ovy = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (tag_s2.center) begin
				rsp_s3.out_col <= principal_x;
				rsp_s3.out_row <= principal_y;
				rsp_s3.status  <= ST_CENTER;
			end else if (tag_s2.sat) begin
				rsp_s3.out_col <= dir_sat(tag_s2.neg_x, tag_s2.mag_x == '0, principal_x);
				rsp_s3.out_row <= dir_sat(tag_s2.neg_y, tag_s2.mag_y == '0, principal_y);
				rsp_s3.status  <= ST_RANGE;
			end else begin
				rsp_s3.out_col <= cx;
				rsp_s3.out_row <= cy;
				rsp_s3.status  <= (ovx || ovy) ? ST_RANGE : ST_NORMAL;
			end
		end
	end

	assign out_valid = v_s3;
	assign out_data  = rsp_s3;
endmodule

FILE: tb/slr_remap_checker.sv
`timescale 1ns / 1ps

module slr_remap_checker (
	input  logic clk,
	input  logic arst_n,
	slr_stream_if pix_in,
	slr_stream_if pix_out,
	slr_stream_if cfg,
	output int   fail_count,
	output int   pending
);
	import slr_pkg::*;

	// shadow copy of the lens registers
	logic signed [31:0] prin_x;
	logic signed [31:0] prin_y;
	logic [31:0]        pitch;
	logic [31:0]        focal;

	pix_rsp_t predicted_q[$];

	assign pending = predicted_q.size();

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res;
		longint unsigned bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x   -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// principal +/- |d|*scale, clamped to 32 bits
	function automatic longint scale_axis(longint p, longint d, longint unsigned mag,
			longint unsigned scale, ref bit ovf);
		logic [127:0] prod;
		longint       m;
		longint       v;
		prod = 128'(mag) * 128'(scale);
		prod = prod >> 32;
		if (prod > 128'h2_0000_0000)
			prod = 128'h2_0000_0000;
		m = longint'(prod[63:0]);
		v = (d < 0) ? p - m : p + m;
		if (v > 64'sh7FFF_FFFF) begin
			ovf = 1;
			return 64'sh7FFF_FFFF;
		end
		if (v < -64'sh8000_0000) begin
			ovf = 1;
			return -64'sh8000_0000;
		end
		return v;
	endfunction

	function automatic longint clip_by_dir(longint d, longint p);
		if (d > 0)
			return 64'sh7FFF_FFFF;
		if (d < 0)
			return -64'sh8000_0000;
		return p;
	endfunction

	function automatic pix_rsp_t remap_point(pix_req_t req);
		longint          px, py, dx, dy, oc, orw;
		longint unsigned ax, ay, nx, ny, ux, uy, s, q, scale;
		logic [127:0]    quot;
		bit              sat;
		bit              ovf;
		pix_rsp_t        rsp;
		px    = longint'(prin_x);
		py    = longint'(prin_y);
		dx    = longint'(req.in_col) - px;
		dy    = longint'(req.in_row) - py;
		ax    = (dx < 0) ? -dx : dx;
		ay    = (dy < 0) ? -dy : dy;
		nx    = ax * longint'(pitch);
		ny    = ay * longint'(pitch);
		sat   = 0;
		ovf   = 0;
		scale = 0;
		if (nx == 0 && ny == 0) begin
			oc  = px;
			orw = py;
			rsp.status = ST_CENTER;
		end else begin
			if (focal == 0) begin
				sat = 1;
			end else begin
				// ratio |p|/f in Q.24
				ux = (nx / longint'(focal)) >> 4;
				uy = (ny / longint'(focal)) >> 4;
				if (ux > 64'h7FFF_FFFF || uy > 64'h7FFF_FFFF)
					sat = 1;
				if (!sat) begin
					s = ux * ux + uy * uy;
					if (req.opcode == OP_FORWARD) begin
						q     = int_sqrt((64'd1 << 48) + s);
						scale = (64'd1 << 57) / ((64'd1 << 24) + q);
					end else if (s >= (64'd1 << 50)) begin
						sat = 1;
					end else begin
						quot = (128'd1 << 82) / 128'((64'd1 << 50) - s);
						if (quot > 128'h7FFF_FFFF_FFFF_FFFF)
							sat = 1;
						else
							scale = quot[63:0];
					end
				end
			end
			if (sat) begin
				oc  = clip_by_dir(dx, px);
				orw = clip_by_dir(dy, py);
				rsp.status = ST_RANGE;
			end else begin
				oc  = scale_axis(px, dx, ax, scale, ovf);
				orw = scale_axis(py, dy, ay, scale, ovf);
				rsp.status = ovf ? ST_RANGE : ST_NORMAL;
			end
		end
		rsp.out_col = oc[31:0];
		rsp.out_row = orw[31:0];
		return rsp;
	endfunction

	// track register writes, predict requests, compare results
	always @(posedge clk or negedge arst_n) begin
		pix_rsp_t exp_rsp;
		if (!arst_n) begin
			prin_x     <= '0;
			prin_y     <= '0;
			pitch      <= PITCH_RST;
			focal      <= FOCAL_RST;
			fail_count <= 0;
			predicted_q.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.data.index)
					REG_PRINCIPAL_X:  prin_x <= cfg.data.wdata;
					REG_PRINCIPAL_Y:  prin_y <= cfg.data.wdata;
					REG_PIXEL_PITCH:  pitch  <= cfg.data.wdata;
					REG_FOCAL_LENGTH: focal  <= cfg.data.wdata;
					default: ;
				endcase
			end
			if (pix_in.valid && pix_in.ready)
				predicted_q.push_back(remap_point(pix_in.data));
			if (pix_out.valid && pix_out.ready) begin
				if (predicted_q.size() == 0) begin
					if (fail_count < 10)
						$display("ERROR: unexpected result col=%h row=%h status=%0d",
							pix_out.data.out_col, pix_out.data.out_row,
							pix_out.data.status);
					fail_count <= fail_count + 1;
				end else begin
					exp_rsp = predicted_q.pop_front();
					if (exp_rsp !== pix_out.data) begin
						if (fail_count < 10)
							$display("ERROR: exp col=%h row=%h st=%0d got col=%h row=%h st=%0d",
								exp_rsp.out_col, exp_rsp.out_row, exp_rsp.status,
								pix_out.data.out_col, pix_out.data.out_row,
								pix_out.data.status);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

FILE: tb/tb_stereographic_lens_remap.sv
`timescale 1ns / 1ps

module tb_stereographic_lens_remap;
	import slr_pkg::*;

	localparam int LATENCY  = 135;
	localparam int WDOG_MAX = 4000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	bit   no_idle;
	int   stall_left;
	int   quiet_cycles = 0;

	logic signed [31:0] cur_px;
	logic signed [31:0] cur_py;

	slr_stream_if #(.payload_t(pix_req_t)) pix_in_if ();
	slr_stream_if #(.payload_t(pix_rsp_t)) pix_out_if ();
	slr_stream_if #(.payload_t(cfg_req_t)) cfg_if ();

	stereographic_lens_remap dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in_if),
		.pix_out (pix_out_if),
		.cfg     (cfg_if)
	);

	slr_remap_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_in     (pix_in_if),
		.pix_out    (pix_out_if),
		.cfg        (cfg_if),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// result side back-pressure: random stall after each result, none while no_idle
	always @(posedge clk or negedge arst_n) begin
		int n;
		if (!arst_n) begin
			pix_out_if.ready <= 1'b0;
			stall_left       <= 0;
		end else if (pix_out_if.ready) begin
			if (pix_out_if.valid) begin
				n = no_idle ? 0 : $urandom_range(0, 15);
				if (n > 0) begin
					pix_out_if.ready <= 1'b0;
					stall_left       <= n - 1;
				end
			end
		end else if (stall_left == 0) begin
			pix_out_if.ready <= 1'b1;
		end else begin
			stall_left <= stall_left - 1;
		end
	end

	// watchdog on cycles with no request, result or register write moving
	always @(posedge clk) begin
		if ((pix_in_if.valid && pix_in_if.ready) || (pix_out_if.valid && pix_out_if.ready)
				|| (cfg_if.valid && cfg_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_MAX) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_point(logic op, logic signed [31:0] col, logic signed [31:0] row);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			pix_in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_in_if.valid       <= 1'b1;
		pix_in_if.data.opcode <= op;
		pix_in_if.data.in_col <= col;
		pix_in_if.data.in_row <= row;
		do
			@(posedge clk);
		while (!pix_in_if.ready);
	endtask

	task automatic drain;
		pix_in_if.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		cfg_if.valid      <= 1'b1;
		cfg_if.data.index <= idx;
		cfg_if.data.wdata <= value;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
		if (idx == REG_PRINCIPAL_X)
			cur_px = value;
		if (idx == REG_PRINCIPAL_Y)
			cur_py = value;
	endtask

	task automatic set_lens(logic [31:0] px, logic [31:0] py, logic [31:0] pitch,
			logic [31:0] focal);
		drain();
		write_reg(REG_PRINCIPAL_X, px);
		write_reg(REG_PRINCIPAL_Y, py);
		write_reg(REG_PIXEL_PITCH, pitch);
		write_reg(REG_FOCAL_LENGTH, focal);
	endtask

	// offset around the principal point, mostly within the lens field
	function automatic logic signed [31:0] near_coord(logic signed [31:0] centre);
		int          sh;
		logic [31:0] off;
		sh  = $urandom_range(0, 30);
		off = $urandom() >> (31 - sh);
		if ($urandom_range(0, 1))
			off = -off;
		return centre + off;
	endfunction

	task automatic random_points(int count);
		logic signed [31:0] col, row;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				col = $urandom();
				row = $urandom();
			end else begin
				col = near_coord(cur_px);
				row = near_coord(cur_py);
				if ($urandom_range(0, 15) == 0)
					col = cur_px;
				if ($urandom_range(0, 15) == 0)
					row = cur_py;
			end
			send_point($urandom_range(0, 1) ? OP_INVERSE : OP_FORWARD, col, row);
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		no_idle           = 1'b0;
		cur_px            = '0;
		cur_py            = '0;
		pix_in_if.valid   = 1'b0;
		pix_in_if.data    = '0;
		cfg_if.valid      = 1'b0;
		cfg_if.data       = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset lens, field extremes, centre, both directions
		send_point(OP_FORWARD, 32'sd0, 32'sd0);
		send_point(OP_INVERSE, 32'sd0, 32'sd0);
		send_point(OP_FORWARD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_point(OP_INVERSE, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_point(OP_FORWARD, 32'sh8000_0000, 32'sh8000_0000);
		send_point(OP_FORWARD, 32'sh0C80_0000, 32'sd0);
		send_point(OP_INVERSE, 32'sh0C80_0000, 32'sd0);
		send_point(OP_INVERSE, 32'sh1900_0000, 32'sd0);
		send_point(OP_INVERSE, 32'sh18FF_0000, -32'sh0010_0000);
		send_point(OP_FORWARD, 32'sd1, -32'sd1);
		send_point(OP_INVERSE, -32'sh0100_0000, 32'sh0200_0000);
		send_point(OP_FORWARD, 32'sd0, 32'sh7FFF_FFFF);

		// principal at the extremes: output overflow both ways
		set_lens(32'h7FFF_FFFF, 32'h8000_0000, PITCH_RST, FOCAL_RST);
		send_point(OP_FORWARD, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_point(OP_FORWARD, 32'sh7F00_0000, 32'sh8100_0000);
		send_point(OP_INVERSE, 32'sh7000_0000, 32'sh9000_0000);
		send_point(OP_INVERSE, 32'sh8000_0000, 32'sh7FFF_FFFF);

		// zero pitch: every point lands on the centre
		set_lens(32'h0010_0000, 32'hFFF0_0000, 32'd0, FOCAL_RST);
		send_point(OP_FORWARD, 32'sh1234_5678, -32'sd5);
		send_point(OP_INVERSE, 32'sh7FFF_FFFF, 32'sh8000_0000);

		// zero focal length: saturated by direction
		set_lens(32'h0010_0000, 32'hFFF0_0000, PITCH_RST, 32'd0);
		send_point(OP_FORWARD, 32'sh0020_0000, 32'shFFF0_0000);
		send_point(OP_INVERSE, 32'sd0, 32'sh7FFF_FFFF);

		// largest pitch, smallest focal: ratio overflow
		set_lens(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1);
		send_point(OP_FORWARD, 32'sd1, 32'sd0);
		send_point(OP_INVERSE, -32'sd1, 32'sh7FFF_FFFF);
		random_points(40);

		// random phases through several lens settings
		set_lens(PITCH_RST ^ PITCH_RST, 32'd0, PITCH_RST, FOCAL_RST);
		random_points(120);
		no_idle = 1'b1;
		set_lens($urandom(), $urandom(), $urandom(), $urandom());
		random_points(60);
		no_idle = 1'b0;
		set_lens($urandom(), $urandom(), $urandom_range(1000000, 100000000),
			$urandom_range(1 << 20, 1 << 26));
		random_points(100);
		set_lens(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		random_points(60);
		set_lens(32'h0100_0000, 32'hFF00_0000, $urandom(), $urandom_range(1, 1 << 16));
		random_points(60);
		set_lens(32'd0, 32'd0, PITCH_RST, FOCAL_RST);
		random_points(60);

		drain();
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: stereographic_lens_remap.f
rtl/core/slr_pkg.sv
rtl/core/slr_stream_if.sv
rtl/core/slr_div_pipe.sv
rtl/core/slr_sqrt_pipe.sv
rtl/core/slr_front.sv
rtl/core/slr_norm.sv
rtl/core/slr_back.sv
rtl/core/stereographic_lens_remap.sv
tb/slr_remap_checker.sv
tb/tb_stereographic_lens_remap.sv
